// File: rtl/skf_pkg.sv
// shared types and constants for the scalar kalman filter unit
// no dependencies
`default_nettype none
package skf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GAIN_BITS = 16;
	localparam int DIV_STEPS = GAIN_BITS + 1;

	localparam logic [31:0] FIX_ONE   = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] Q_RESET   = 32'((64'd65 << FRAC_BITS) >> 16);
	localparam logic [GAIN_BITS:0] GAIN_ONE = (GAIN_BITS + 1)'(1 << GAIN_BITS);

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ESTIMATE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_COVARIANCE = 8'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic den;
		logic div_first;
		logic div_step;
		logic mul1;
		logic mul2;
		logic fin;
	} skf_cmd_t;

endpackage
`default_nettype wire

// File: rtl/scalar_kalman_filter_unit.sv
// top level of the scalar kalman filter unit: stream ports, config port
// depends on skf_pkg, skf_ctrl, skf_datapath
// a request runs through the states DEN, DIV (the 17-step restoring divider), MUL1, MUL2 and FIN
// the unit takes no new request before the last one has left FIN
// the result sits in an output register, so a stalled result does not block acceptance of the next request
// arst_n resets control, the config registers and the filter state to their defaults
`default_nettype none
module scalar_kalman_filter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sample
	input  wire logic        s_tuser,   // [0] restart
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // [31:0] estimate, [63:32] covariance, [80:64] gain
	// config write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);

	skf_pkg::skf_cmd_t cmd;

	logic [31:0]                 est_out;
	logic [31:0]                 cov_out;
	logic [skf_pkg::GAIN_BITS:0] gain_out;

	// config registers are always writable; writes must come only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	skf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (s_tdata),
		.restart    (s_tuser),
		.estimate   (est_out),
		.covariance (cov_out),
		.gain       (gain_out)
	);

	// pack result fields, pad to whole bytes
	assign m_tdata = {7'd0, gain_out, cov_out, est_out};

	// one request in flight: accepting closes the input side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted while one is in flight");

	// gain never exceeds one
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[80:64] <= skf_pkg::GAIN_ONE))
		else $error("gain above one");

	// the divider never runs while the input side is open
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !s_tready)
		else $error("divider active while ready");

	// a result is written only when the output register is free or drained
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// File: rtl/skf_ctrl.sv
// sequencing state machine for the scalar kalman filter unit
// depends on skf_pkg
`default_nettype none
module skf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output skf_pkg::skf_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEN  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [4:0] step_q;
	logic       out_valid_q;
	logic       fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign fire      = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.den       = (state_q == ST_DEN);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_first = (state_q == ST_DIV) && (step_q == 5'd0);
		cmd.mul1      = (state_q == ST_MUL1);
		cmd.mul2      = (state_q == ST_MUL2);
		cmd.fin       = (state_q == ST_FIN) && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DEN;
				end
				ST_DEN: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 5'(skf_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_MUL1;
					end
					step_q <= step_q + 5'd1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					if (fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/skf_datapath.sv
// registers, divider and multipliers of the scalar kalman filter unit
// depends on skf_pkg
`default_nettype none
module skf_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire skf_pkg::skf_cmd_t               cmd,
	input  wire logic                            cfg_we,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire logic [31:0]                     sample,
	input  wire logic                            restart,
	output logic [31:0]                          estimate,
	output logic [31:0]                          covariance,
	output logic [skf_pkg::GAIN_BITS:0]          gain
);

	localparam int GW = skf_pkg::GAIN_BITS + 1;

	logic [31:0] q_noise_q, r_noise_q, start_est_q, start_cov_q;
	logic [31:0] est_cur_q, cov_cur_q;

	logic [31:0] sample_q, est_q, pred_q;
	logic [32:0] den_q, innov_q;
	logic        den_zero_q;
	logic [33:0] rem_q;
	logic [GW-1:0] quot_q, gain_q;
	logic signed [GW+33:0] prod_e_q;
	logic [GW+31:0] prod_c_q;
	logic [31:0] est_new_q;

	logic [31:0] sel_est, sel_cov;
	logic [32:0] pred_sum;
	logic [33:0] rem_t;
	logic        rem_ge;
	logic [GW-1:0] gain_use;
	logic [31:0] cov_new;

	assign sel_est  = restart ? start_est_q : est_cur_q;
	assign sel_cov  = restart ? start_cov_q : cov_cur_q;
	assign pred_sum = {1'b0, sel_cov} + {1'b0, q_noise_q};

	// first step tests the integer bit, later steps shift in zeros
	assign rem_t  = cmd.div_first ? rem_q : {rem_q[32:0], 1'b0};
	assign rem_ge = rem_t >= {1'b0, den_q};

	assign gain_use = den_zero_q ? '0 : quot_q;
	assign cov_new  = prod_c_q[skf_pkg::GAIN_BITS +: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q   <= skf_pkg::Q_RESET;
			r_noise_q   <= skf_pkg::FIX_ONE;
			start_est_q <= '0;
			start_cov_q <= skf_pkg::FIX_ONE;
			est_cur_q   <= '0;
			cov_cur_q   <= skf_pkg::FIX_ONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					skf_pkg::REG_PROCESS_NOISE:    q_noise_q   <= cfg_data;
					skf_pkg::REG_MEASURE_NOISE:    r_noise_q   <= cfg_data;
					skf_pkg::REG_START_ESTIMATE:   start_est_q <= cfg_data;
					skf_pkg::REG_START_COVARIANCE: start_cov_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.fin) begin
				est_cur_q <= est_new_q;
				cov_cur_q <= cov_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			est_q    <= sel_est;
			pred_q   <= pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
		end
		if (cmd.den) begin
			den_q      <= {1'b0, pred_q} + {1'b0, r_noise_q};
			den_zero_q <= (pred_q == '0) && (r_noise_q == '0);
			innov_q    <= {sample_q[31], sample_q} - {est_q[31], est_q};
			rem_q      <= {2'b00, pred_q};
			quot_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? rem_t - {1'b0, den_q} : rem_t;
			quot_q <= {quot_q[GW-2:0], rem_ge};
		end
		if (cmd.mul1) begin
			gain_q   <= gain_use;
			prod_e_q <= $signed({1'b0, gain_use}) * $signed(innov_q);
		end
		if (cmd.mul2) begin
			prod_c_q  <= (skf_pkg::GAIN_ONE - gain_q) * pred_q;
			// arithmetic shift of the product is the floor of the scaled step
			est_new_q <= est_q + prod_e_q[skf_pkg::GAIN_BITS +: 32];
		end
		if (cmd.fin) begin
			estimate   <= est_new_q;
			covariance <= cov_new;
			gain       <= gain_q;
		end
	end

endmodule
`default_nettype wire

// File: tb/skf_checker.sv
// result checker for the scalar kalman filter unit: tracks config writes and requests,
// predicts each filter update and compares it with the result stream
// depends on skf_pkg
module skf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int          failures,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] estimate;
		logic [31:0]        covariance;
		logic [16:0]        gain;
	} filt_out_t;

	// register copies
	logic [31:0]        q_noise, r_noise, start_cov;
	logic signed [31:0] start_est;
	// filter state
	logic signed [31:0] est_state;
	logic [31:0]        cov_state;

	filt_out_t expected_q[$];

	initial failures = 0;
	initial pending = 0;

	// one filter step: predict, gain, estimate update, covariance update
	function automatic filt_out_t kalman_update(input logic signed [31:0] smp, input logic rst);
		logic [32:0] wide;
		logic [31:0] pred;
		logic [32:0] den;
		logic [63:0] gain64;
		logic [63:0] cov64;
		longint      innov;
		longint      delta;
		filt_out_t   res;
		if (rst) begin
			est_state = start_est;
			cov_state = start_cov;
		end
		wide = {1'b0, cov_state} + {1'b0, q_noise};
		pred = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
		den = {1'b0, pred} + {1'b0, r_noise};
		gain64 = (den == '0) ? 64'd0 : {16'd0, pred, 16'd0} / {31'd0, den};
		innov = longint'(smp) - longint'(est_state);
		delta = (longint'(gain64) * innov) >>> skf_pkg::GAIN_BITS;
		est_state = est_state + delta[31:0];
		cov64 = ((64'(skf_pkg::GAIN_ONE) - gain64) * {32'd0, pred}) >> skf_pkg::GAIN_BITS;
		cov_state = cov64[31:0];
		res.estimate = est_state;
		res.covariance = cov_state;
		res.gain = gain64[16:0];
		return res;
	endfunction

	task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		filt_out_t want;
		if (!arst_n) begin
			q_noise = skf_pkg::Q_RESET;
			r_noise = skf_pkg::FIX_ONE;
			start_est = '0;
			start_cov = skf_pkg::FIX_ONE;
			est_state = '0;
			cov_state = skf_pkg::FIX_ONE;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					skf_pkg::REG_PROCESS_NOISE:    q_noise = cfg_data;
					skf_pkg::REG_MEASURE_NOISE:    r_noise = cfg_data;
					skf_pkg::REG_START_ESTIMATE:   start_est = cfg_data;
					skf_pkg::REG_START_COVARIANCE: start_cov = cfg_data;
					default: ;
				endcase
			end
			// results first, so a result never meets the request of the same edge
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
					failures++;
				end else begin
					want = expected_q.pop_front();
					report("estimate", want.estimate, m_tdata[31:0]);
					report("covariance", want.covariance, m_tdata[63:32]);
					report("gain", 32'(want.gain), 32'(m_tdata[80:64]));
					report("padding", 32'd0, 32'(m_tdata[87:81]));
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(kalman_update(s_tdata, s_tuser));
		end
		pending = expected_q.size();
	end

endmodule

// File: tb/tb_top.sv
// top of the scalar kalman filter testbench: clock, reset, stimulus and verdict
// depends on skf_pkg, scalar_kalman_filter_unit and skf_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// the slowest correct run stays well under this limit
	localparam int CYCLE_LIMIT = 500_000;
	// extra wait at the end, after every result is back
	localparam int DRAIN_CYCLES = 40;
	localparam int RAND_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 72;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input stream
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] sample
	logic        s_tuser = 1'b0; // [0] restart
	// result stream
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;        // [31:0] estimate, [63:32] covariance, [80:64] gain
	// config channel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [skf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int failures;
	int pending;
	int cycles = 0;

	// idle rates in percent for the request side and the result side
	int send_idle_pct = 6;
	int recv_idle_pct = 80;

	always #5 clk = ~clk;

	scalar_kalman_filter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	skf_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	// result side backpressure, one decision per cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one measurement request; valid stays high into the next request unless a gap is drawn
	task automatic send_sample(input logic [31:0] smp, input logic rst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= rst;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and wait until every result is back, so config may change
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input logic [31:0] q, input logic [31:0] r,
		input logic [31:0] est0, input logic [31:0] cov0);
		write_reg(skf_pkg::REG_PROCESS_NOISE, q);
		write_reg(skf_pkg::REG_MEASURE_NOISE, r);
		write_reg(skf_pkg::REG_START_ESTIMATE, est0);
		write_reg(skf_pkg::REG_START_COVARIANCE, cov0);
	endtask

	// noise variances: mostly modest so the gain moves around, sometimes extreme
	function automatic logic [31:0] pick_noise();
		case ($urandom_range(7))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return skf_pkg::FIX_ONE;
			3: return $urandom;
			default: return $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// samples: full range, extremes, and values near zero like a real sensor
	function automatic logic [31:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: plain steps and the sample extremes
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		settle();

		// largest start covariance: predicted covariance saturates
		load_regs(skf_pkg::Q_RESET, skf_pkg::FIX_ONE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'h7FFF_FFFF, 1'b0);
		settle();

		// noise and start covariance at their top, start estimate most negative: widest denominator and saturation each step
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample(32'h0000_0000, 1'b0);
		settle();

		// zero denominator: gain zero, estimate held
		load_regs('0, '0, 32'h0003_0000, '0);
		send_sample(32'h7FFF_0000, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		settle();

		// zero measurement noise: gain one, estimate follows the sample
		load_regs(skf_pkg::FIX_ONE, '0, '0, skf_pkg::FIX_ONE);
		send_sample(32'h1234_5678, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		settle();

		// writes past the last register must change nothing
		write_reg(skf_pkg::CFG_IDX_W'(4), $urandom);
		write_reg('1, 32'hFFFF_FFFF);
		write_reg(skf_pkg::CFG_IDX_W'(8'h80), 32'h5555_AAAA);
		send_sample(32'h0002_0000, 1'b0);
		send_sample(32'hFFFE_0000, 1'b1);
		settle();

		// random phases, three per idling mode, modes in order
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph / 3)
				0: begin send_idle_pct = 6; recv_idle_pct = 80; end
				1: begin send_idle_pct = 80; recv_idle_pct = 6; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			load_regs(pick_noise(), pick_noise(), pick_word(), pick_word());
			if ($urandom_range(1))
				write_reg(skf_pkg::CFG_IDX_W'($urandom_range(4, 255)), $urandom);
			// first request reloads the start values so each phase begins fresh
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_sample(pick_sample(), (n == 0) || ($urandom_range(19) == 0));
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: scalar_kalman_filter_unit.f
rtl/skf_pkg.sv
rtl/skf_ctrl.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter_unit.sv
tb/skf_checker.sv
tb/tb_top.sv
